// ===== design/igr_pkg.sv =====
// Shared types and constants for the int8 GELU requantiser.
`timescale 1ns / 1ps
`default_nettype none

package igr_pkg;

   // Field and datapath widths
   localparam int SAMPLE_W = 8;
   localparam int X_W      = 10;   // sample plus input offset
   localparam int D_W      = 9;    // clipped polynomial argument, -128..0
   localparam int DSQ_W    = 18;   // full signed square of d
   localparam int DD_W     = 15;   // d*d, at most 16384
   localparam int DIFF_W   = 18;   // unit_value - d*d
   localparam int UL_W     = 19;   // unit_value + L
   localparam int H_W      = 18;   // (unit_value + L) >> 1
   localparam int XH_W     = X_W + H_W;
   localparam int WORD_W   = 32;
   localparam int SHIFT_W  = 5;
   localparam int ADDR_W   = 5;

   // Output clamp limits
   localparam logic signed [WORD_W-1:0]   CLAMP_LO   = -32'sd128;
   localparam logic signed [WORD_W-1:0]   CLAMP_HI   = 32'sd127;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -8'sd128;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 8'sd127;

   // Register map, index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_ERF_OFFSET    = 3'd0,
      REG_UNIT_VALUE    = 3'd1,
      REG_IN_OFFSET     = 3'd2,
      REG_OUT_OFFSET    = 3'd3,
      REG_REQUANT_MUL   = 3'd4,
      REG_REQUANT_ADD   = 3'd5,
      REG_REQUANT_SHIFT = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [7:0]         erf_offset;
      logic signed [15:0]        unit_value;
      logic signed [8:0]         in_offset;
      logic signed [8:0]         out_offset;
      logic [WORD_W-1:0]         requant_mul;
      logic [WORD_W-1:0]         requant_add;
      logic [SHIFT_W-1:0]        requant_shift;
   } cfg_type;

   // Hand-over from the polynomial pipe to the requant pipe
   typedef struct packed {
      logic signed [X_W-1:0] x;
      logic signed [H_W-1:0] h;
      logic                  last;
   } gate_type;

endpackage

`default_nettype wire

// ===== design/igr_if.sv =====
// Valid/ready stream interfaces for the request and response channels.
`timescale 1ns / 1ps
`default_nettype none

interface igr_req_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample_in;
   logic              last_in;

   modport source (output valid, output sample_in, output last_in, input ready);
   modport sink   (input valid, input sample_in, input last_in, output ready);
endinterface

interface igr_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] sample_out;
   logic              last_out;

   modport source (output valid, output sample_out, output last_out, input ready);
   modport sink   (input valid, input sample_out, input last_out, output ready);
endinterface

`default_nettype wire

// ===== design/igr_csr.sv =====
// APB-style configuration register file for the GELU requantiser.
`timescale 1ns / 1ps
`default_nettype none

module igr_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [igr_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      logic                        pready,
   output      igr_pkg::cfg_type            cfg
);
   import igr_pkg::*;

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   logic          wr_en;
   reg_index_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = reg_index_type'(paddr[ADDR_W-1:2]);
   assign cfg    = cfg_ff;

   // Register write decode; unmapped index is ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (idx)
            REG_ERF_OFFSET:    cfg_in.erf_offset    = pwdata[7:0];
            REG_UNIT_VALUE:    cfg_in.unit_value    = pwdata[15:0];
            REG_IN_OFFSET:     cfg_in.in_offset     = pwdata[8:0];
            REG_OUT_OFFSET:    cfg_in.out_offset    = pwdata[8:0];
            REG_REQUANT_MUL:   cfg_in.requant_mul   = pwdata;
            REG_REQUANT_ADD:   cfg_in.requant_add   = pwdata;
            REG_REQUANT_SHIFT: cfg_in.requant_shift = pwdata[SHIFT_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{erf_offset: '0, unit_value: '0, in_offset: '0, out_offset: '0,
                     requant_mul: 32'd1, requant_add: '0, requant_shift: 5'd1};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read-back, signed fields sign-extended
   always_comb begin
      unique case (idx)
         REG_ERF_OFFSET:    prdata = {{24{cfg_ff.erf_offset[7]}}, cfg_ff.erf_offset};
         REG_UNIT_VALUE:    prdata = {{16{cfg_ff.unit_value[15]}}, cfg_ff.unit_value};
         REG_IN_OFFSET:     prdata = {{23{cfg_ff.in_offset[8]}}, cfg_ff.in_offset};
         REG_OUT_OFFSET:    prdata = {{23{cfg_ff.out_offset[8]}}, cfg_ff.out_offset};
         REG_REQUANT_MUL:   prdata = cfg_ff.requant_mul;
         REG_REQUANT_ADD:   prdata = cfg_ff.requant_add;
         REG_REQUANT_SHIFT: prdata = {27'd0, cfg_ff.requant_shift};
         default:           prdata = '0;
      endcase
   end

   // Checks
   a_shift_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && idx == REG_REQUANT_SHIFT) |=> cfg_ff.requant_shift == $past(pwdata[4:0]))
      else $error("shift register did not take written value");

   a_mul_write: assert property (@(posedge clock) disable iff (reset)
      (wr_en && idx == REG_REQUANT_MUL) |=> cfg_ff.requant_mul == $past(pwdata))
      else $error("multiplier register did not take written value");

   a_no_write_hold: assert property (@(posedge clock) disable iff (reset)
      !wr_en |=> $stable(cfg_ff))
      else $error("configuration changed without a write");

endmodule

`default_nettype wire

// ===== design/igr_erf.sv =====
// Four-stage pipe: input offset, erf polynomial clip, square, gate value h.
`timescale 1ns / 1ps
`default_nettype none

module igr_erf (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire igr_pkg::cfg_type             cfg,
   input  wire logic                         in_valid,
   output      logic                         in_ready,
   input  wire logic signed [7:0]            sample,
   input  wire logic                         last,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      igr_pkg::gate_type            gate
);
   import igr_pkg::*;

   localparam int STAGES = 4;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   // Stage 0: x
   logic signed [X_W-1:0]  x0_ff, x0_in;
   logic                   last0_ff;
   // Stage 1: d and sign
   logic signed [X_W-1:0]  x1_ff;
   logic signed [D_W-1:0]  d1_ff, d1_in;
   logic                   pos1_ff, neg1_ff, last1_ff;
   // Stage 2: d*d
   logic signed [X_W-1:0]  x2_ff;
   logic [DD_W-1:0]        dd2_ff, dd2_in;
   logic                   pos2_ff, neg2_ff, last2_ff;
   // Stage 3: output
   gate_type               gate_ff, gate_in;

   // Stage-1 helpers
   logic                   pos1_in, neg1_in;
   logic [X_W-1:0]         xa;
   logic signed [X_W:0]    xa_s, nb_s, q_s, d_s, b_s;
   // Stage-2 helpers
   logic signed [DSQ_W-1:0] dsq;
   // Stage-3 helpers
   logic signed [DIFF_W-1:0] diff, poly;
   logic signed [UL_W-1:0]   ul;

   // Per-stage ready: a stage loads when empty or its successor moves
   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign valid_in  = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready  = rdy[0];
   assign out_valid = valid_ff[STAGES-1];
   assign gate      = gate_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~rdy) | (valid_in & rdy);
      end
   end

   // x = sample + in_offset
   assign x0_in = {{2{sample[7]}}, sample} + {cfg.in_offset[8], cfg.in_offset};

   // q = min(|x|, -b), d = q + b
   always_comb begin
      pos1_in = !x0_ff[X_W-1] && (x0_ff != '0);
      neg1_in = x0_ff[X_W-1];
      xa      = neg1_in ? -x0_ff : x0_ff;
      xa_s    = {1'b0, xa};
      b_s     = {{3{cfg.erf_offset[7]}}, cfg.erf_offset};
      nb_s    = -b_s;
      q_s     = (xa_s > nb_s) ? nb_s : xa_s;
      d_s     = q_s + b_s;
      d1_in   = d_s[D_W-1:0];
   end

   // d*d
   assign dsq    = d1_ff * d1_ff;
   assign dd2_in = dsq[DD_W-1:0];

   // L = sgn(x) * (one - d*d), h = (one + L) >> 1
   always_comb begin
      diff = {{2{cfg.unit_value[15]}}, cfg.unit_value} - {3'd0, dd2_ff};
      if (pos2_ff) begin
         poly = diff;
      end else if (neg2_ff) begin
         poly = -diff;
      end else begin
         poly = '0;
      end
      ul           = {{3{cfg.unit_value[15]}}, cfg.unit_value} + {poly[DIFF_W-1], poly};
      gate_in.x    = x2_ff;
      gate_in.h    = ul[UL_W-1:1];
      gate_in.last = last2_ff;
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         x0_ff    <= x0_in;
         last0_ff <= last;
      end
      if (rdy[1]) begin
         x1_ff    <= x0_ff;
         d1_ff    <= d1_in;
         pos1_ff  <= pos1_in;
         neg1_ff  <= neg1_in;
         last1_ff <= last0_ff;
      end
      if (rdy[2]) begin
         x2_ff    <= x1_ff;
         dd2_ff   <= dd2_in;
         pos2_ff  <= pos1_ff;
         neg2_ff  <= neg1_ff;
         last2_ff <= last1_ff;
      end
      if (rdy[3]) begin
         gate_ff <= gate_in;
      end
   end

   // Checks
   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("polynomial pipe not empty after reset");

   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      (in_valid && in_ready) |=> valid_ff[0])
      else $error("accepted beat did not enter first stage");

   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid && $stable(gate_ff))
      else $error("stalled gate beat was lost or changed");

endmodule

`default_nettype wire

// ===== design/igr_rq.sv =====
// Five-stage requant pipe: x*h, *mul, +add, rounding shift, offset and clamp.
`timescale 1ns / 1ps
`default_nettype none

module igr_rq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire igr_pkg::cfg_type             cfg,
   input  wire logic                         in_valid,
   output      logic                         in_ready,
   input  wire igr_pkg::gate_type            gate,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      logic signed [7:0]            sample_out,
   output      logic                         last_out
);
   import igr_pkg::*;

   localparam int STAGES = 5;

   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] valid_in;
   logic [STAGES-1:0] rdy;

   logic [WORD_W-1:0]       y0_ff, y0_in;
   logic [WORD_W-1:0]       p1_ff, p1_in;
   logic [WORD_W-1:0]       t2_ff, t2_in;
   logic [WORD_W-1:0]       u3_ff, u3_in;
   logic signed [SAMPLE_W-1:0] s4_ff, s4_in;
   logic                    last0_ff, last1_ff, last2_ff, last3_ff, last4_ff;

   logic signed [XH_W-1:0]  xh;
   logic [WORD_W-1:0]       rnd, rsum;
   logic signed [WORD_W-1:0] v;

   // Per-stage ready: a stage loads when empty or its successor moves
   always_comb begin
      rdy[STAGES-1] = !valid_ff[STAGES-1] || out_ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
   end

   assign valid_in   = {valid_ff[STAGES-2:0], in_valid};
   assign in_ready   = rdy[0];
   assign out_valid  = valid_ff[STAGES-1];
   assign sample_out = s4_ff;
   assign last_out   = last4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= (valid_ff & ~rdy) | (valid_in & rdy);
      end
   end

   // y = x * h, fits 28 bits
   assign xh    = $signed(gate.x) * $signed(gate.h);
   assign y0_in = {{(WORD_W - XH_W){xh[XH_W-1]}}, xh};

   // Low word of y * mul, then bias; both wrap
   assign p1_in = y0_ff * cfg.requant_mul;
   assign t2_in = p1_ff + cfg.requant_add;

   // Rounding arithmetic shift; a zero shift adds nothing
   always_comb begin
      rnd   = (cfg.requant_shift == '0) ? '0
              : (32'd1 << (cfg.requant_shift - 5'd1));
      rsum  = t2_ff + rnd;
      u3_in = WORD_W'($signed(rsum) >>> cfg.requant_shift);
   end

   // Output offset and saturation to signed 8 bits
   always_comb begin
      v = $signed(u3_ff + {{23{cfg.out_offset[8]}}, cfg.out_offset});
      priority if (v < CLAMP_LO) begin
         s4_in = SAMPLE_MIN;
      end else if (v > CLAMP_HI) begin
         s4_in = SAMPLE_MAX;
      end else begin
         s4_in = v[SAMPLE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         y0_ff    <= y0_in;
         last0_ff <= gate.last;
      end
      if (rdy[1]) begin
         p1_ff    <= p1_in;
         last1_ff <= last0_ff;
      end
      if (rdy[2]) begin
         t2_ff    <= t2_in;
         last2_ff <= last1_ff;
      end
      if (rdy[3]) begin
         u3_ff    <= u3_in;
         last3_ff <= last2_ff;
      end
      if (rdy[4]) begin
         s4_ff    <= s4_in;
         last4_ff <= last3_ff;
      end
   end

   // Checks
   a_reset_empty: assert property (@(posedge clock)
      reset |=> valid_ff == '0)
      else $error("requant pipe not empty after reset");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[2] && !rdy[3]) |=> valid_ff[2] && $stable(t2_ff))
      else $error("stalled middle stage dropped its beat");

   a_count: assert property (@(posedge clock) disable iff (reset)
      (!(in_valid && in_ready) && !(out_valid && out_ready))
      |=> $countones(valid_ff) == $past($countones(valid_ff)))
      else $error("beat count changed without a handshake");

endmodule

`default_nettype wire

// ===== design/int8_gelu_requant.sv =====
// Top level of the integer-only GELU with int8 requantisation.
// int8_gelu_requant takes one signed 8-bit activation per beat and returns one
// signed 8-bit GELU result per beat, with the last flag carried alongside. It
// accepts a new beat every clock cycle while the response channel is not
// stalled; each beat passes four stages for the erf polynomial (offset, clip,
// square, gate) and five for requantisation (x*h, the 32x32 multiply, bias,
// rounding shift, offset and clamp), the multiply setting the stage depth.
// Every stage holds its beat while the one after it is full, so back-pressure
// on the response channel loses nothing and bubbles close up. Registers sit on
// an APB-style port at byte addresses 4*i and must only be written while the
// pipe is empty.
`timescale 1ns / 1ps
`default_nettype none

module int8_gelu_requant (
   input  wire logic                        clock,
   input  wire logic                        reset,
   igr_req_if.sink                          req_if,
   igr_rsp_if.source                        rsp_if,
   input  wire logic                        psel,
   input  wire logic                        penable,
   input  wire logic                        pwrite,
   input  wire logic [igr_pkg::ADDR_W-1:0]  paddr,
   input  wire logic [31:0]                 pwdata,
   output      logic [31:0]                 prdata,
   output      logic                        pready
);
   import igr_pkg::*;

   cfg_type  cfg;
   gate_type gate;
   logic     gate_valid;
   logic     gate_ready;

   // Configuration registers
   igr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // erf polynomial pipe
   igr_erf u_erf (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_if.valid),
      .in_ready  (req_if.ready),
      .sample    (req_if.sample_in),
      .last      (req_if.last_in),
      .out_valid (gate_valid),
      .out_ready (gate_ready),
      .gate      (gate)
   );

   // Requantisation pipe, last stage is the response register
   igr_rq u_rq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (gate_valid),
      .in_ready   (gate_ready),
      .gate       (gate),
      .out_valid  (rsp_if.valid),
      .out_ready  (rsp_if.ready),
      .sample_out (rsp_if.sample_out),
      .last_out   (rsp_if.last_out)
   );

endmodule

`default_nettype wire
